### hdl/ascii_ppm_stream_parser_top_macros.svh
// Assertion macros shared by the checker of the PPM parser.
`ifndef ASCII_PPM_STREAM_PARSER_TOP_MACROS_SVH
`define ASCII_PPM_STREAM_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during rst.
`define PPMP_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during rst.
`define PPMP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### hdl/ppmp_pkg.sv
`timescale 1ns / 1ps
package ppmp_pkg;

  // Result kinds, carried on tuser of the output stream.
  localparam logic [2:0] KIND_WIDTH  = 3'd0;
  localparam logic [2:0] KIND_HEIGHT = 3'd1;
  localparam logic [2:0] KIND_MAXVAL = 3'd2;
  localparam logic [2:0] KIND_SAMPLE = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // Parse phases.
  localparam logic [2:0] PH_MAGIC0 = 3'd0;
  localparam logic [2:0] PH_MAGIC1 = 3'd1;
  localparam logic [2:0] PH_HEADER = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  // Characters of interest.
  localparam logic [7:0] CH_MAGIC_P = 8'h50;
  localparam logic [7:0] CH_MAGIC_3 = 8'h33;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Number of header fields (width, height, maxval).
  localparam logic [1:0] HDR_FIELDS = 2'd3;
  localparam logic [1:0] LAST_CHANNEL = 2'd2;

  // Normalized value of full scale in Q1.16.
  localparam logic [16:0] NORM_ONE = 17'h10000;

  // One quotient bit per divider step.
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_res_t;

endpackage

### hdl/ppmp_divider.sv
`timescale 1ns / 1ps
// Restoring divider: quotient = (dividend << 16) / divisor, dividend < divisor.
module ppmp_divider
  import ppmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output div_res_t    res
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [16:0]          rem;
  logic [15:0]          quo;
  logic [15:0]          dvs;
  logic [16:0]          shifted;
  logic                 fits;

  // The remainder stays below the divisor, so one left shift fits 17 bits.
  assign shifted = {rem[15:0], 1'b0};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend};
      quo <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, dvs}) : shifted;
      quo <= {quo[14:0], fits};
    end
  end

  assign res.done     = done;
  assign res.quotient = quo;

endmodule

### hdl/ascii_ppm_stream_parser_top.sv
// ASCII PPM (P3) stream parser.
// The slave stream takes one file byte per word on s_tdata, with s_tlast set on
// the final byte of a file. The master stream returns one word per header
// field, per sample, or one format error; m_tuser carries the kind of the word.
// A byte that ends no number and is no bad magic byte returns nothing.
// A byte that completes a header field, an error, or a sample that
// saturates at full scale has its word on the output register in the cycle after
// acceptance. A sample below maxval goes through the 16-step restoring
// divider, its word is registered when the divider signals done, and no byte is
// taken while the division runs. Other bytes are taken at one per cycle while
// no division runs and the receiver does not stall.
// s_tready is high only while no division runs and the output register is
// empty or being emptied in that cycle. When the receiver stalls, the word is
// held and no further bytes are taken until it leaves.
// Synchronous reset clears the parse state to "expect magic" and empties the
// output register. A byte with s_tlast also returns the parser to that state
// once its own result, including a flushed final number, has been produced.
`timescale 1ns / 1ps
module ascii_ppm_stream_parser_top
  import ppmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] item_value, [17:16] channel_index,
                                 // [34:18] normalized_sample, [39:35] zero
  output logic [2:0]  m_tuser    // [2:0] item_kind
);

  // Sequencer codes.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic        state;

  // Parse state.
  logic [2:0]  phase, phase_next;
  logic [1:0]  hdr_done, hdr_done_next;
  logic [15:0] acc, acc_next;
  logic        seen, seen_next;
  logic        in_cmt, in_cmt_next;
  logic [15:0] maxv, maxv_next;
  logic [1:0]  chan, chan_next;

  // Result of the current byte.
  logic        res_valid;
  logic [2:0]  res_kind;
  logic [15:0] res_value;
  logic [1:0]  res_ch;
  logic        res_sample;
  logic        full_scale;
  logic        need_div;

  logic        is_digit;
  logic [19:0] acc_wide;
  logic [15:0] acc_sat;
  logic        accept;

  // Pending sample during a division.
  logic [15:0] pend_value;
  logic [1:0]  pend_ch;
  div_res_t    div_res;

  // Output register.
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [15:0] out_value;
  logic [1:0]  out_ch;
  logic [16:0] out_norm;

  assign s_tready = (state == ST_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  // acc * 10 + digit as shift-and-add; the digit is the low nibble of its code.
  assign acc_wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, s_tdata[3:0]};
  assign acc_sat  = (|acc_wide[19:16]) ? 16'hFFFF : acc_wide[15:0];

  always_comb begin
    phase_next    = phase;
    hdr_done_next = hdr_done;
    acc_next      = acc;
    seen_next     = seen;
    in_cmt_next   = in_cmt;
    maxv_next     = maxv;
    chan_next     = chan;
    res_valid     = 1'b0;
    res_kind      = KIND_WIDTH;
    res_value     = '0;
    res_ch        = '0;
    res_sample    = 1'b0;

    unique case (phase)
      PH_MAGIC0, PH_MAGIC1: begin
        if (s_tdata == ((phase == PH_MAGIC0) ? CH_MAGIC_P : CH_MAGIC_3)) begin
          phase_next = phase + 3'd1;
        end else begin
          res_valid  = 1'b1;
          res_kind   = KIND_ERROR;
          phase_next = PH_ERROR;
        end
      end
      PH_HEADER: begin
        if (in_cmt) begin
          if (s_tdata == CH_NEWLINE) begin
            in_cmt_next = 1'b0;
          end
        end else if (is_digit) begin
          if (hdr_done == HDR_FIELDS) begin
            phase_next = PH_DATA;
          end
          acc_next  = acc_sat;
          seen_next = 1'b1;
        end else begin
          if (seen && hdr_done != HDR_FIELDS) begin
            res_valid     = 1'b1;
            res_kind      = {1'b0, hdr_done};
            res_value     = acc;
            hdr_done_next = hdr_done + 2'd1;
            if ({1'b0, hdr_done} == KIND_MAXVAL) begin
              maxv_next = acc;
            end
            acc_next  = '0;
            seen_next = 1'b0;
          end
          if (s_tdata == CH_HASH) begin
            in_cmt_next = 1'b1;
          end
        end
      end
      PH_DATA: begin
        if (is_digit) begin
          acc_next  = acc_sat;
          seen_next = 1'b1;
        end else if (seen) begin
          res_valid  = 1'b1;
          res_kind   = KIND_SAMPLE;
          res_value  = acc;
          res_ch     = chan;
          res_sample = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // A final number with no separator after it is flushed on the last byte.
    if (s_tlast && !res_valid && seen_next) begin
      if (phase_next == PH_HEADER && hdr_done_next != HDR_FIELDS) begin
        res_valid = 1'b1;
        res_kind  = {1'b0, hdr_done_next};
        res_value = acc_next;
      end else if (phase_next == PH_DATA) begin
        res_valid  = 1'b1;
        res_kind   = KIND_SAMPLE;
        res_value  = acc_next;
        res_ch     = chan;
        res_sample = 1'b1;
      end
    end

    if (res_sample) begin
      chan_next = (chan == LAST_CHANNEL) ? 2'd0 : chan + 2'd1;
      acc_next  = '0;
      seen_next = 1'b0;
    end

    // The last byte of a file returns all parse state to its reset values.
    if (s_tlast) begin
      phase_next    = PH_MAGIC0;
      hdr_done_next = '0;
      acc_next      = '0;
      seen_next     = 1'b0;
      in_cmt_next   = 1'b0;
      maxv_next     = '0;
      chan_next     = '0;
    end
  end

  // maxval 0 and a sample at or above maxval both read as full scale.
  assign full_scale = (maxv == 16'd0) || (res_value >= maxv);
  assign need_div   = res_sample && !full_scale;

  ppmp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && need_div),
    .dividend (res_value),
    .divisor  (maxv),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_MAGIC0;
      hdr_done  <= '0;
      acc       <= '0;
      seen      <= 1'b0;
      in_cmt    <= 1'b0;
      maxv      <= '0;
      chan      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            phase    <= phase_next;
            hdr_done <= hdr_done_next;
            acc      <= acc_next;
            seen     <= seen_next;
            in_cmt   <= in_cmt_next;
            maxv     <= maxv_next;
            chan     <= chan_next;
            if (need_div) begin
              state <= ST_DIV;
            end else if (res_valid) begin
              out_valid <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      pend_value <= res_value;
      pend_ch    <= res_ch;
      if (res_valid && !need_div) begin
        out_kind  <= res_kind;
        out_value <= res_value;
        out_ch    <= res_ch;
        out_norm  <= res_sample ? NORM_ONE : 17'd0;
      end
    end else if (state == ST_DIV && div_res.done) begin
      out_kind  <= KIND_SAMPLE;
      out_value <= pend_value;
      out_ch    <= pend_ch;
      out_norm  <= {1'b0, div_res.quotient};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {5'd0, out_norm, out_ch, out_value};

endmodule

### hdl/ppmp_checker.sv
`timescale 1ns / 1ps
`include "ascii_ppm_stream_parser_top_macros.svh"
module ppmp_checker
  import ppmp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // A stalled word is held unchanged.
  `PPMP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

  // Only samples carry a channel and a normalized value.
  `PPMP_ASSERT_NOW(a_non_sample_zero, m_tvalid && m_tuser != KIND_SAMPLE, m_tdata[34:16] == 19'd0, "non-sample word has channel or normalized bits")

  // Sample fields stay in range: channel below three, value at most 1.0.
  `PPMP_ASSERT_NOW(a_sample_range, m_tvalid && m_tuser == KIND_SAMPLE, m_tdata[17:16] != 2'd3 && m_tdata[34:18] <= NORM_ONE, "sample field out of range")

  // A byte accepted while a word waits requires that word to leave now.
  `PPMP_ASSERT_NOW(a_no_overrun, s_tvalid && s_tready, !m_tvalid || m_tready, "byte accepted while output stalled")

endmodule

bind ascii_ppm_stream_parser_top ppmp_checker u_ppmp_checker (.*);

### test/tb_ascii_ppm_stream_parser_top.sv
`timescale 1ns / 1ps
module tb_ascii_ppm_stream_parser_top;
  import ppmp_pkg::*;

  localparam int QUIET_TAIL = 150;   // No idling once fewer bytes than this remain.
  localparam int TARGET_BYTES = 1200;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold;   // Wait for every outstanding word before sending this byte.
  } file_byte_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
    logic [1:0]  chan;
    logic [16:0] norm;
  } ppm_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;

  ascii_ppm_stream_parser_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  file_byte_t pending_bytes[$];
  ppm_word_t  expected_words[$];

  int  total_bytes = 0;
  int  bytes_taken = 0;
  int  files_done = 0;
  int  words_checked = 0;
  int  mismatches = 0;
  int  kind_seen[5];
  bit  took_byte = 1'b0;
  bit  calm = 1'b0;
  int  tx_idle = 0;
  int  rx_idle = 0;

  // Parser state mirrored by the predictor.
  logic [2:0]  parse_state;
  logic [1:0]  fields_done;
  logic [15:0] num_acc;
  bit          have_digits;
  bit          in_comment;
  logic [15:0] full_scale;
  logic [1:0]  channel;

  task automatic clear_parser();
    parse_state = PH_MAGIC0;
    fields_done = '0;
    num_acc     = '0;
    have_digits = 1'b0;
    in_comment  = 1'b0;
    full_scale  = '0;
    channel     = '0;
  endtask

  function automatic logic [16:0] scale_to_q16(logic [15:0] v, logic [15:0] fs);
    logic [31:0] num;
    if (fs == 16'd0 || v >= fs) return NORM_ONE;
    num = {v, 16'h0000};
    return 17'(num / {16'h0000, fs});
  endfunction

  task automatic take_digit(input logic [7:0] b);
    logic [31:0] acc;
    acc = num_acc * 32'd10 + 32'(b - CH_ZERO);
    num_acc = (acc > 32'd65535) ? 16'hFFFF : acc[15:0];
    have_digits = 1'b1;
  endtask

  task automatic header_word(output bit got, output ppm_word_t w);
    w = '0;
    got = 1'b0;
    // A fourth header field never exists; the first digit after maxval starts the data.
    if ({1'b0, fields_done} > KIND_MAXVAL) return;
    if ({1'b0, fields_done} == KIND_MAXVAL) full_scale = num_acc;
    w.kind = {1'b0, fields_done};
    w.value = num_acc;
    fields_done = fields_done + 2'd1;
    num_acc = '0;
    have_digits = 1'b0;
    got = 1'b1;
  endtask

  task automatic sample_word(output bit got, output ppm_word_t w);
    w = '0;
    w.kind = KIND_SAMPLE;
    w.value = num_acc;
    w.chan = channel;
    w.norm = scale_to_q16(num_acc, full_scale);
    channel = (channel == LAST_CHANNEL) ? 2'd0 : channel + 2'd1;
    num_acc = '0;
    have_digits = 1'b0;
    got = 1'b1;
  endtask

  // Advances the mirrored parser by one file byte and returns the word it causes, if any.
  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output bit got, output ppm_word_t w);
    bit is_digit;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    got = 1'b0;
    w = '0;
    case (parse_state)
      PH_MAGIC0, PH_MAGIC1: begin
        if (b == ((parse_state == PH_MAGIC0) ? CH_MAGIC_P : CH_MAGIC_3)) begin
          parse_state = parse_state + 3'd1;
        end else begin
          w.kind = KIND_ERROR;
          got = 1'b1;
          parse_state = PH_ERROR;
        end
      end
      PH_HEADER: begin
        if (in_comment) begin
          if (b == CH_NEWLINE) in_comment = 1'b0;
        end else if (is_digit) begin
          if (fields_done >= HDR_FIELDS) parse_state = PH_DATA;
          take_digit(b);
        end else begin
          if (have_digits) header_word(got, w);
          if (b == CH_HASH) in_comment = 1'b1;
        end
      end
      PH_DATA: begin
        if (is_digit) take_digit(b);
        else if (have_digits) sample_word(got, w);
      end
      default: ;
    endcase
    // The final byte flushes a pending number and then restarts the parser.
    if (last) begin
      if (!got && have_digits) begin
        if (parse_state == PH_HEADER) header_word(got, w);
        else if (parse_state == PH_DATA) sample_word(got, w);
      end
      clear_parser();
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last, input bit hold);
    file_byte_t fb;
    fb.data = b;
    fb.last = last;
    fb.hold = hold;
    pending_bytes.push_back(fb);
  endtask

  task automatic push_text(input string s, input bit hold);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], (i == s.len() - 1), hold && (i == 0));
  endtask

  task automatic push_run(input logic [7:0] run[$]);
    foreach (run[i]) push_byte(run[i], (i == run.size() - 1), 1'b0);
  endtask

  task automatic push_number(input int v, input bit last_at_end);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], last_at_end && (i == s.len() - 1), 1'b0);
  endtask

  function automatic logic [7:0] pick_sep(bit in_data);
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0, 1, 2: b = CH_SPACE;
      3: b = CH_NEWLINE;
      4: b = CH_TAB;
      5: b = CH_CR;
      6: begin
        do b = 8'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || (!in_data && b == CH_HASH));
      end
      default: b = in_data ? CH_HASH : CH_COMMA;
    endcase
    return b;
  endfunction

  // One or two separators; in the header sometimes a comment, which may hold digits.
  task automatic push_gap(input bit in_data);
    logic [7:0] b;
    int n;
    n = $urandom_range(1, 2);
    for (int i = 0; i < n; i++) push_byte(pick_sep(in_data), 1'b0, 1'b0);
    if (!in_data && $urandom_range(0, 3) == 0) begin
      push_byte(CH_HASH, 1'b0, 1'b0);
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        do b = 8'($urandom_range(0, 255));
        while (b == CH_NEWLINE);
        push_byte(b, 1'b0, 1'b0);
      end
      push_byte(CH_NEWLINE, 1'b0, 1'b0);
    end
  endtask

  function automatic int rand_size();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99999) : $urandom_range(0, 640);
  endfunction

  task automatic gen_file();
    logic [7:0] run[$];
    logic [7:0] b;
    int pick, nsamp, fs, v, n;
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      // Well-formed file with random content.
      push_byte(CH_MAGIC_P, 1'b0, ($urandom_range(0, 11) == 0));
      push_byte(CH_MAGIC_3, 1'b0, 1'b0);
      if ($urandom_range(0, 3) != 0) push_gap(1'b0);
      push_number(rand_size(), 1'b0);
      push_gap(1'b0);
      push_number(rand_size(), 1'b0);
      push_gap(1'b0);
      case ($urandom_range(0, 9))
        0: fs = 0;
        1: fs = 65535;
        2: fs = $urandom_range(65536, 99999);
        3: fs = $urandom_range(256, 65535);
        default: fs = $urandom_range(1, 255);
      endcase
      push_number(fs, 1'b0);
      push_gap(1'b0);
      nsamp = $urandom_range(1, 15);
      for (int i = 0; i < nsamp; i++) begin
        if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 99999);
        else v = $urandom_range(0, (fs > 65535) ? 65535 : fs);
        if (i != nsamp - 1) begin
          push_number(v, 1'b0);
          push_gap(1'b1);
        end else if ($urandom_range(0, 1) == 0) begin
          push_number(v, 1'b1);
        end else begin
          push_number(v, 1'b0);
          push_byte(pick_sep(1'b1), 1'b1, 1'b0);
        end
      end
    end else if (pick < 86) begin
      // Bad magic on either byte, then bytes that must be ignored.
      if ($urandom_range(0, 1) == 0) begin
        do b = 8'($urandom_range(0, 255));
        while (b == CH_MAGIC_P);
        run.push_back(b);
      end else begin
        run.push_back(CH_MAGIC_P);
        do b = 8'($urandom_range(0, 255));
        while (b == CH_MAGIC_3);
        run.push_back(b);
      end
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) run.push_back(8'($urandom_range(0, 255)));
      push_run(run);
    end else if (pick < 94) begin
      // File cut short inside the magic or the header.
      if ($urandom_range(0, 3) == 0) begin
        push_byte(CH_MAGIC_P, 1'b1, 1'b0);
      end else begin
        push_byte(CH_MAGIC_P, 1'b0, 1'b0);
        push_byte(CH_MAGIC_3, 1'b0, 1'b0);
        push_gap(1'b0);
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
          push_number(rand_size(), 1'b0);
          push_gap(1'b0);
        end
        if ($urandom_range(0, 1) == 0) begin
          push_number(rand_size(), 1'b1);
        end else begin
          push_number(rand_size(), 1'b0);
          push_byte(pick_sep(1'b0), 1'b1, 1'b0);
        end
      end
    end else begin
      // Raw noise.
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) run.push_back(8'($urandom_range(0, 255)));
      push_run(run);
    end
  endtask

  // Sender: presents one file byte per word, holding it until it is taken.
  always @(negedge clk) begin
    file_byte_t nxt;
    if (!rst) begin
      if (s_tvalid && !took_byte) begin
        // Word still waiting for s_tready.
      end else if (tx_idle > 0) begin
        s_tvalid <= 1'b0;
        tx_idle--;
      end else if (pending_bytes.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (pending_bytes[0].hold && expected_words.size() != 0) begin
        s_tvalid <= 1'b0;
      end else begin
        nxt = pending_bytes.pop_front();
        s_tdata  <= nxt.data;
        s_tlast  <= nxt.last;
        s_tvalid <= 1'b1;
        if (!calm && pending_bytes.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
          tx_idle = $urandom_range(1, 8);
      end
    end
  end

  // Receiver: stalls in bursts; the calm flag gives long stretches without stalls.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) calm = !calm;
    if (rx_idle > 0) begin
      m_tready <= 1'b0;
      rx_idle--;
    end else begin
      m_tready <= 1'b1;
      if (!calm && pending_bytes.size() >= QUIET_TAIL && $urandom_range(0, 6) == 0)
        rx_idle = $urandom_range(1, 8);
    end
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Checks each output word against the oldest prediction, then predicts for the input word.
  always @(posedge clk) begin
    ppm_word_t want, got_word;
    bit got;
    took_byte = 1'b0;
    if (rst) begin
      clear_parser();
    end else begin
      if (m_tvalid && m_tready) begin
        got_word.kind  = m_tuser;
        got_word.value = m_tdata[15:0];
        got_word.chan  = m_tdata[17:16];
        got_word.norm  = m_tdata[34:18];
        if (expected_words.size() == 0) begin
          note_mismatch($sformatf("unexpected word kind=%0d value=%0d ch=%0d norm=%0d",
                                  got_word.kind, got_word.value, got_word.chan, got_word.norm));
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (want.kind <= KIND_ERROR) kind_seen[want.kind]++;
          if (got_word !== want || m_tdata[39:35] !== 5'd0)
            note_mismatch($sformatf(
              "exp kind=%0d value=%0d ch=%0d norm=%0d, got kind=%0d value=%0d ch=%0d norm=%0d pad=%0h",
              want.kind, want.value, want.chan, want.norm, got_word.kind, got_word.value,
              got_word.chan, got_word.norm, m_tdata[39:35]));
        end
      end
      if (s_tvalid && s_tready) begin
        took_byte = 1'b1;
        bytes_taken++;
        if (s_tlast) files_done++;
        parse_byte(s_tdata, s_tlast, got, want);
        if (got) expected_words.push_back(want);
      end
    end
  end

  initial begin
    // Directed files: both magic errors, one with an ignored byte, header comments, maxval 3
    // with a comment after it, '#' as a data separator, a flushed final sample,
    // saturation of a header field, maxval 0 with a flushed zero, a truncated header
    // and a lone first magic byte.
    push_text("XP", 1'b0);
    push_text("P6", 1'b0);
    push_text("P3#x\n2 1 3 #z\n0 2 9#7", 1'b1);
    push_text("P399999 0 0 65535 0", 1'b0);
    push_text("P3 70", 1'b0);
    push_text("P", 1'b0);
    push_text("P31 1 65535\n65535 1 0 65534 70000\n", 1'b1);
    while (pending_bytes.size() < TARGET_BYTES) gen_file();
    total_bytes = pending_bytes.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_taken < total_bytes || expected_words.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d bytes in %0d files; checked %0d words.", bytes_taken, files_done,
             words_checked);
    $display("Words by kind: %0d width, %0d height, %0d maxval, %0d sample, %0d error; %0d bad.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4], mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
